// File: design/acpf_pkg.sv
package acpf_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] period_estimate;
      logic       flat_input;
      logic       length_overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic accumulate;
      logic start_eval;
      logic eval_step;
      logic clear_all;
   } ctrl_cmd_type;

   typedef struct packed {
      logic eval_done;
   } dp_status_type;

endpackage

// File: design/acpf_ctrl.sv
module acpf_ctrl
   import acpf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_EVAL, ST_WAIT, ST_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.accumulate = (state_ff == ST_IDLE) && req_valid;
      cmd.start_eval = (state_ff == ST_IDLE) && req_valid && req_last;
      cmd.eval_step  = (state_ff == ST_EVAL);
      cmd.clear_all  = (state_ff == ST_OUT) && !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_last) state_ff <= ST_PREP;
            end
            ST_PREP: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (status.eval_done) state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               state_ff     <= ST_OUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT) else $error("rsp_valid outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.eval_step |-> !cmd.accumulate) else $error("accept during evaluation");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff) else $error("result dropped");

endmodule

// File: design/acpf_datapath.sv
module acpf_datapath
   import acpf_pkg::*;
#(
   parameter int MAX_BYTES = 4096,
   parameter int LAG_COUNT = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status,
   output rsp_payload_type rsp_data
);

   localparam int CW = $clog2(MAX_BYTES + 1);
   localparam int SW = CW + 8;
   localparam int TW = CW + 16;
   localparam int LW = $clog2(LAG_COUNT + 1);
   localparam int LI = (LAG_COUNT > 1) ? $clog2(LAG_COUNT) : 1;
   localparam int NNW = 2 * CW;
   localparam int SSW = 2 * SW;
   localparam int NSW = CW + SW;
   localparam int ABW = SW + 1;
   localparam int NTW = NNW + TW;
   localparam int DSW = CW + SSW;
   localparam int NAW = NSW + ABW;
   localparam int KW = NNW + TW + 2;
   localparam int MW = KW + CW;

   logic [CW-1:0] count_ff;
   logic [SW-1:0] sum_ff;
   logic [7:0]    head_ff   [LAG_COUNT];
   logic [7:0]    recent_ff [LAG_COUNT];
   logic [TW-1:0] prod_ff   [LAG_COUNT];
   logic          ovf_ff, differ_ff;

   logic       take;
   logic [7:0] x;
   assign x    = req_data.data_byte;
   assign take = cmd.accumulate && (count_ff < CW'(MAX_BYTES));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         ovf_ff    <= 1'b0;
         differ_ff <= 1'b0;
         for (int j = 0; j < LAG_COUNT; j++) begin
            recent_ff[j] <= '0;
            prod_ff[j]   <= '0;
         end
      end else if (cmd.accumulate) begin
         if (take) begin
            for (int j = 0; j < LAG_COUNT; j++) begin
               if (count_ff > CW'(j))
                  prod_ff[j] <= prod_ff[j] + TW'({8'h00, x} * {8'h00, recent_ff[j]});
            end
            for (int j = LAG_COUNT - 1; j > 0; j--) recent_ff[j] <= recent_ff[j-1];
            recent_ff[0] <= x;
            if (count_ff != '0 && x != head_ff[0]) differ_ff <= 1'b1;
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SW'(x);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < LAG_COUNT; j++) begin
         if (take && count_ff == CW'(j)) head_ff[j] <= x;
      end
   end

   // evaluation: one lag at a time in phases: 0 form K terms, 1 subtract, 2/3 compare
   logic [LW-1:0]  lag_ff;
   logic [1:0]     ph_ff;
   logic [SW-1:0]  hsum_ff, tsum_ff;
   logic [NNW-1:0] nn_ff;
   logic [SSW-1:0] ss_ff;
   logic [NSW-1:0] ns_ff;
   logic [KW-1:0]  pos_ff, neg_ff, mag_ff, best_mag_ff;
   logic [CW-1:0]  den_ff, best_den_ff;
   logic [MW-1:0]  lhs_ff, rhs_ff;
   logic [LW-1:0]  best_lag_ff;
   logic           any_ff, done_ff;

   logic [LI-1:0]  idx;
   logic [SW-1:0]  hs_n, ts_n;
   logic [CW-1:0]  den_n;
   logic [ABW-1:0] ab_w;
   logic [NTW-1:0] nt_w;
   logic [DSW-1:0] dss_w;
   logic [NAW-1:0] nab_w;
   logic           lag_ok;
   assign idx    = LI'(lag_ff - 1'b1);
   assign hs_n   = hsum_ff + SW'(head_ff[idx]);
   assign ts_n   = tsum_ff + SW'(recent_ff[idx]);
   assign lag_ok = CW'(lag_ff) < count_ff;
   assign den_n  = count_ff - CW'(lag_ff);
   assign ab_w   = ABW'(sum_ff - ts_n) + ABW'(sum_ff - hs_n);
   assign nt_w   = NTW'(nn_ff) * NTW'(prod_ff[idx]);
   assign dss_w  = DSW'(den_n) * DSW'(ss_ff);
   assign nab_w  = NAW'(ns_ff) * NAW'(ab_w);

   always_ff @(posedge clock) begin
      if (reset || cmd.start_eval) begin
         lag_ff      <= LW'(1);
         ph_ff       <= '0;
         hsum_ff     <= '0;
         tsum_ff     <= '0;
         any_ff      <= 1'b0;
         done_ff     <= 1'b0;
         best_lag_ff <= LW'(1);
         best_mag_ff <= '0;
         best_den_ff <= CW'(1);
      end else if (cmd.eval_step && !done_ff) begin
         ph_ff <= ph_ff + 1'b1;
         case (ph_ff)
            2'd0: begin
               if (!lag_ok) begin
                  done_ff <= 1'b1;
               end else begin
                  hsum_ff <= hs_n;
                  tsum_ff <= ts_n;
                  pos_ff  <= KW'(nt_w) + KW'(dss_w);
                  neg_ff  <= KW'(nab_w);
                  den_ff  <= den_n;
               end
            end
            2'd1: mag_ff <= (pos_ff >= neg_ff) ? pos_ff - neg_ff : neg_ff - pos_ff;
            2'd2: begin
               lhs_ff <= MW'(mag_ff) * MW'(best_den_ff);
               rhs_ff <= MW'(best_mag_ff) * MW'(den_ff);
            end
            default: begin
               if (!any_ff || lhs_ff > rhs_ff) begin
                  best_mag_ff <= mag_ff;
                  best_den_ff <= den_ff;
                  best_lag_ff <= lag_ff;
               end
               any_ff <= 1'b1;
               if (lag_ff == LW'(LAG_COUNT)) done_ff <= 1'b1;
               else lag_ff <= lag_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      nn_ff <= NNW'(count_ff) * NNW'(count_ff);
      ss_ff <= SSW'(sum_ff) * SSW'(sum_ff);
      ns_ff <= NSW'(count_ff) * NSW'(sum_ff);
   end

   logic flat;
   assign flat = !any_ff || !differ_ff;
   assign status.eval_done = done_ff;
   assign rsp_data.period_estimate = flat ? 6'd1 : 6'(best_lag_ff);
   assign rsp_data.flat_input      = flat;
   assign rsp_data.length_overflow = ovf_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BYTES)) else $error("count beyond max");
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      best_lag_ff != '0) else $error("zero lag chosen");
   a_done_stays: assert property (@(posedge clock) disable iff (reset)
      done_ff && !cmd.start_eval |=> done_ff) else $error("done dropped");

endmodule

// File: design/autocorrelation_period_finder_unit.sv
// Autocorrelation period finder.
// req channel: one message byte per transaction plus a last-byte mark.
// Bytes are taken one per cycle while the unit is idle; all lag sums update in parallel.
// After the last byte the unit passes a prep state while its squares settle, then
// evaluates each lag below the message length, up to LAG_COUNT, in turn on one shared
// K/compare unit; the result is registered and offered once the last lag is done.
// rsp channel: one transaction per message with the chosen lag, a flat flag
// and a length-overflow flag. While evaluating or holding a result the
// req channel is stalled.
// A stalled result is held unchanged until taken; then state clears and
// the next message may begin on the following cycle.
// Bytes beyond MAX_BYTES are dropped and flagged.
// Reset clears all counters and sums; the unit is idle after it.
module autocorrelation_period_finder_unit
   import acpf_pkg::*;
#(
   parameter int MAX_BYTES = 4096,
   parameter int LAG_COUNT = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   acpf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_last(req_data.last_byte), .req_stall,
      .rsp_valid, .rsp_stall, .cmd, .status
   );

   acpf_datapath #(.MAX_BYTES(MAX_BYTES), .LAG_COUNT(LAG_COUNT)) u_dp (
      .clock, .reset, .req_data, .cmd, .status, .rsp_data
   );

endmodule

// File: bench/tb_autocorrelation_period_finder_unit.sv
`timescale 1ns / 1ps

module tb_autocorrelation_period_finder_unit;
   import acpf_pkg::*;

   localparam int MAX_LEN = 4096;
   localparam int LAGS = 32;
   localparam int EVAL_CYCLES = 4 * LAGS + 3;
   localparam longint CYCLE_LIMIT = 3000000;

   localparam int MODE_RANDOM = 0;
   localparam int MODE_REPEAT = 1;
   localparam int MODE_FLAT   = 2;
   localparam int MODE_NOISY  = 3;

   class period_scoreboard;
      int unsigned msg_len;
      int unsigned msg_sum;
      byte unsigned head_q[LAGS];
      byte unsigned recent_q[LAGS];
      int unsigned lag_sums[LAGS];
      bit overflow_seen;
      bit bytes_differ;
      rsp_payload_type expected_q[$];
      int errors;

      function void clear_message();
         msg_len = 0;
         msg_sum = 0;
         overflow_seen = 0;
         bytes_differ = 0;
         foreach (head_q[j]) begin
            head_q[j] = 0;
            recent_q[j] = 0;
            lag_sums[j] = 0;
         end
      endfunction

      function void note_byte(req_payload_type tr);
         int unsigned head_acc;
         int unsigned tail_acc;
         int unsigned best_lag;
         int unsigned best_den;
         int unsigned den;
         logic [127:0] best_mag;
         logic [127:0] pos;
         logic [127:0] neg;
         logic [127:0] mag;
         logic [127:0] n;
         logic [127:0] s;
         bit any;
         bit flat;
         rsp_payload_type rsp;
         if (msg_len < MAX_LEN) begin
            for (int j = 0; j < LAGS; j++)
               if (msg_len > j) lag_sums[j] += tr.data_byte * recent_q[j];
            for (int j = LAGS - 1; j > 0; j--) recent_q[j] = recent_q[j-1];
            recent_q[0] = tr.data_byte;
            if (msg_len < LAGS) head_q[msg_len] = tr.data_byte;
            if (msg_len > 0 && tr.data_byte != head_q[0]) bytes_differ = 1;
            msg_len++;
            msg_sum += tr.data_byte;
         end else begin
            overflow_seen = 1;
         end
         if (!tr.last_byte) return;
         n = msg_len;
         s = msg_sum;
         head_acc = 0;
         tail_acc = 0;
         best_lag = 1;
         best_den = 1;
         best_mag = 0;
         any = 0;
         for (int j = 0; j < LAGS; j++) begin
            head_acc += head_q[j];
            tail_acc += recent_q[j];
            if (j + 1 >= msg_len) break;
            den = msg_len - (j + 1);
            pos = n * n * lag_sums[j] + den * s * s;
            neg = n * s * ((s - tail_acc) + (s - head_acc));
            mag = (pos >= neg) ? pos - neg : neg - pos;
            if (!any || mag * best_den > best_mag * den) begin
               best_mag = mag;
               best_den = den;
               best_lag = j + 1;
            end
            any = 1;
         end
         flat = !any || !bytes_differ;
         rsp.period_estimate = flat ? 6'd1 : best_lag[5:0];
         rsp.flat_input = flat;
         rsp.length_overflow = overflow_seen;
         expected_q = {expected_q, rsp};
         clear_message();
      endfunction

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result transaction", 0, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.period_estimate != want.period_estimate)
            report_mismatch("period_estimate", want.period_estimate, got.period_estimate);
         if (got.flat_input != want.flat_input)
            report_mismatch("flat_input", want.flat_input, got.flat_input);
         if (got.length_overflow != want.length_overflow)
            report_mismatch("length_overflow", want.length_overflow, got.length_overflow);
      endtask

      task report_mismatch(string what, int want, int got);
         errors++;
         if (errors <= 40) $display("mismatch %s: expected %0d got %0d", what, want, got);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_payload_type rsp_data;

   period_scoreboard board;
   longint cycle_count = 0;
   int hold_off = 0;
   bit steady_rx = 0;

   autocorrelation_period_finder_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else if (steady_rx) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ((cycle_count / 64) % 3 == 2) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_byte(input byte unsigned value, input bit last, input bit allow_gap);
      req_payload_type tr;
      if (allow_gap && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      tr.data_byte = value;
      tr.last_byte = last;
      req_valid <= 1;
      req_data <= tr;
      do @(posedge clock); while (req_stall);
      board.note_byte(tr);
   endtask

   task automatic send_message(input int len, input int mode, input int period);
      byte unsigned key[64];
      byte unsigned value;
      foreach (key[j]) key[j] = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         case (mode)
            MODE_RANDOM: value = 8'($urandom);
            MODE_REPEAT: value = key[i % period];
            MODE_FLAT:   value = 8'hA5;
            default: value = key[i % period] ^
                             (($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
         endcase
         send_byte(value, i == len - 1, 1);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (EVAL_CYCLES + 10) @(posedge clock);
   endtask

   int sent;
   int len;

   initial begin
      board = new();
      board.clear_message();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_byte(8'h00, 1, 0);
      send_byte(8'hFF, 0, 0);
      send_byte(8'h00, 1, 0);
      send_byte(8'hFF, 0, 0);
      send_byte(8'hFF, 1, 0);
      send_message(8, MODE_REPEAT, 3);
      send_message(6, MODE_FLAT, 1);
      send_message(5, MODE_RANDOM, 1);
      drain();

      steady_rx = 1;
      send_message(33, MODE_RANDOM, 1);
      send_message(32, MODE_REPEAT, 5);
      send_message(40, MODE_FLAT, 1);
      for (int i = 0; i < 63; i++) send_byte(8'h00, 0, 0);
      send_byte(8'h80, 1, 0);
      steady_rx = 0;
      drain();

      hold_off = 400;
      send_message(10, MODE_REPEAT, 4);
      send_message(12, MODE_RANDOM, 1);
      send_message(9, MODE_NOISY, 2);
      drain();

      sent = 0;
      while (sent < 1600) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 40);
         send_message(len, $urandom_range(MODE_RANDOM, MODE_NOISY), $urandom_range(1, 33));
         sent += len;
      end
      drain();

      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
